// ===== design/mpd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the MQTT packet deframer.
// No dependencies; imported by the interface users and all design modules.
package mpd_pkg;

  // parse phase codes
  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_LEN   = 2'd1;
  localparam logic [1:0] PH_DATA  = 2'd2;

  // link state codes
  localparam logic [1:0] LK_WAIT = 2'd0;
  localparam logic [1:0] LK_CONN = 2'd1;
  localparam logic [1:0] LK_REJ  = 2'd2;
  localparam logic [1:0] LK_FAIL = 2'd3;

  // byte roles
  localparam logic [1:0] ROLE_FIRST   = 2'd0;
  localparam logic [1:0] ROLE_LEN     = 2'd1;
  localparam logic [1:0] ROLE_PAYLOAD = 2'd2;
  localparam logic [1:0] ROLE_IGNORED = 2'd3;

  // fault codes
  localparam logic [3:0] FLT_NONE        = 4'd0;
  localparam logic [3:0] FLT_BAD_TYPE    = 4'd1;
  localparam logic [3:0] FLT_OVERLONG    = 4'd2;
  localparam logic [3:0] FLT_NOT_CONNECT = 4'd3;
  localparam logic [3:0] FLT_BAD_NAME    = 4'd4;
  localparam logic [3:0] FLT_RSVD_FLAG   = 4'd5;
  localparam logic [3:0] FLT_WILL_QOS    = 4'd6;
  localparam logic [3:0] FLT_PUB_QOS     = 4'd7;
  localparam logic [3:0] FLT_SUB_HDR     = 4'd8;

  // packet types
  localparam logic [3:0] TYPE_CONNECT   = 4'd1;
  localparam logic [3:0] TYPE_PUBLISH   = 4'd3;
  localparam logic [3:0] TYPE_SUBSCRIBE = 4'd8;

  localparam logic [7:0]  SUBSCRIBE_HDR   = 8'h82;
  localparam logic [7:0]  PROTO_LEVEL     = 8'd4;
  localparam logic [2:0]  LEN_MAX_BYTES   = 3'd4;
  localparam logic [27:0] PROTO_NAME_LEN  = 28'd6;
  localparam logic [27:0] LEVEL_OFFSET    = 28'd6;
  localparam logic [27:0] FLAGS_OFFSET    = 28'd7;
  localparam logic [27:0] CONNECT_MIN_LEN = 28'd8;
  localparam logic [4:0]  TYPE_LIMIT_RST  = 5'd15;

  typedef struct packed {
    logic [7:0] rx_byte;
  } mpd_in_t;

  typedef struct packed {
    logic [4:0] type_limit;
  } mpd_cfg_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [3:0]  packet_type;
    logic [3:0]  header_flags;
    logic [1:0]  byte_role;
    logic [27:0] payload_offset;
    logic        packet_end;
    logic [1:0]  link_state;
    logic [3:0]  fault;
  } mpd_out_t;

  typedef struct packed {
    logic [1:0]  parse_phase;
    logic [1:0]  conn_phase;
    logic [3:0]  cur_type;
    logic [3:0]  cur_flags;
    logic [27:0] remaining_length;
    logic [2:0]  length_byte_count;
    logic [27:0] payload_count;
  } mpd_state_t;

  localparam mpd_state_t STATE_RST = '{
    parse_phase:       PH_FIRST,
    conn_phase:        LK_WAIT,
    cur_type:          4'd0,
    cur_flags:         4'd0,
    remaining_length:  28'd0,
    length_byte_count: 3'd0,
    payload_count:     28'd0
  };

  // expected protocol name bytes: 00 04 'M' 'Q' 'T' 'T'
  function automatic logic [7:0] proto_name_byte(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = 8'h00;
      3'd1:    v = 8'h04;
      3'd2:    v = 8'h4D;
      3'd3:    v = 8'h51;
      3'd4:    v = 8'h54;
      3'd5:    v = 8'h54;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ===== design/mpd_chan_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload item per handshake.
// Payload type is set per instance; used with the types of mpd_pkg.
interface mpd_chan_if #(
  parameter type payload_t = logic [7:0]
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/mpd_step.sv =====
`timescale 1ns / 1ps
// Per-byte parse step: next state and result item from current state and byte.
// Depends on mpd_pkg.
module mpd_step (
  input  mpd_pkg::mpd_state_t st,
  input  logic [7:0]          rx_byte,
  input  logic [4:0]          type_limit,
  output mpd_pkg::mpd_state_t st_nxt,
  output mpd_pkg::mpd_out_t   res
);
  import mpd_pkg::*;

  logic [27:0] len_part;
  logic [27:0] rl_new;
  logic [2:0]  lbc_new;
  logic [27:0] pc_new;
  logic        wait_connect;
  logic [3:0]  fault;
  logic [1:0]  role;
  logic        pkt_end;
  logic [27:0] offset;

  always_comb begin
    case (st.length_byte_count[1:0])
      2'd0:    len_part = {21'd0, rx_byte[6:0]};
      2'd1:    len_part = {14'd0, rx_byte[6:0], 7'd0};
      2'd2:    len_part = {7'd0, rx_byte[6:0], 14'd0};
      default: len_part = {rx_byte[6:0], 21'd0};
    endcase
    rl_new       = st.remaining_length | len_part;
    lbc_new      = st.length_byte_count + 3'd1;
    pc_new       = st.payload_count + 28'd1;
    wait_connect = (st.conn_phase == LK_WAIT) && (st.cur_type == TYPE_CONNECT);

    st_nxt  = st;
    fault   = FLT_NONE;
    role    = ROLE_FIRST;
    pkt_end = 1'b0;
    offset  = 28'd0;

    case (st.parse_phase)
      PH_FIRST: begin
        role                     = ROLE_FIRST;
        st_nxt.cur_type          = rx_byte[7:4];
        st_nxt.cur_flags         = rx_byte[3:0];
        st_nxt.remaining_length  = 28'd0;
        st_nxt.length_byte_count = 3'd0;
        st_nxt.payload_count     = 28'd0;
        st_nxt.parse_phase       = PH_LEN;
        if (rx_byte[7:4] == 4'd0 || {1'b0, rx_byte[7:4]} >= type_limit) begin
          fault = FLT_BAD_TYPE;
        end else if (st.conn_phase == LK_WAIT && rx_byte[7:4] != TYPE_CONNECT) begin
          fault = FLT_NOT_CONNECT;
        end else if (st.conn_phase == LK_CONN && rx_byte[7:4] == TYPE_PUBLISH &&
                     rx_byte[2:1] == 2'b11) begin
          fault = FLT_PUB_QOS;
        end else if (st.conn_phase == LK_CONN && rx_byte[7:4] == TYPE_SUBSCRIBE &&
                     rx_byte != SUBSCRIBE_HDR) begin
          fault = FLT_SUB_HDR;
        end
      end
      PH_LEN: begin
        role                     = ROLE_LEN;
        st_nxt.remaining_length  = rl_new;
        st_nxt.length_byte_count = lbc_new;
        if (rx_byte[7]) begin
          if (lbc_new >= LEN_MAX_BYTES) begin
            fault = FLT_OVERLONG;
          end
        end else if (rl_new == 28'd0) begin
          // empty packet: a connect with no payload is always too short
          pkt_end            = 1'b1;
          st_nxt.parse_phase = PH_FIRST;
          if (wait_connect) begin
            fault = FLT_BAD_NAME;
          end
        end else begin
          st_nxt.parse_phase = PH_DATA;
        end
      end
      default: begin
        role   = ROLE_PAYLOAD;
        offset = st.payload_count;
        if (wait_connect) begin
          if (st.payload_count < PROTO_NAME_LEN) begin
            if (rx_byte != proto_name_byte(st.payload_count[2:0])) begin
              fault = FLT_BAD_NAME;
            end
          end else if (st.payload_count == LEVEL_OFFSET) begin
            if (rx_byte != PROTO_LEVEL) begin
              st_nxt.conn_phase = LK_REJ;
            end
          end else if (st.payload_count == FLAGS_OFFSET) begin
            if (rx_byte[0]) begin
              fault = FLT_RSVD_FLAG;
            end else if (rx_byte[2] && rx_byte[4:3] == 2'b11) begin
              fault = FLT_WILL_QOS;
            end
          end
        end
        st_nxt.payload_count = pc_new;
        if (pc_new >= st.remaining_length) begin
          pkt_end            = 1'b1;
          st_nxt.parse_phase = PH_FIRST;
          if (fault == FLT_NONE && st_nxt.conn_phase == LK_WAIT &&
              st.cur_type == TYPE_CONNECT) begin
            if (pc_new < CONNECT_MIN_LEN) begin
              fault = FLT_BAD_NAME;
            end else begin
              st_nxt.conn_phase = LK_CONN;
            end
          end
        end
      end
    endcase

    if (fault != FLT_NONE) begin
      st_nxt.conn_phase = LK_FAIL;
    end

    res.data_byte      = rx_byte;
    res.packet_type    = st_nxt.cur_type;
    res.header_flags   = st_nxt.cur_flags;
    res.byte_role      = role;
    res.payload_offset = offset;
    res.packet_end     = pkt_end;
    res.link_state     = st_nxt.conn_phase;
    res.fault          = fault;

    // failed link: hold all state, pass bytes through as ignored
    if (st.conn_phase == LK_FAIL) begin
      st_nxt             = st;
      res.packet_type    = 4'd0;
      res.header_flags   = 4'd0;
      res.byte_role      = ROLE_IGNORED;
      res.payload_offset = 28'd0;
      res.packet_end     = 1'b0;
      res.link_state     = LK_FAIL;
      res.fault          = FLT_NONE;
    end
  end

endmodule

// ===== design/mqtt_packet_deframer.sv =====
`timescale 1ns / 1ps
// Top level of the MQTT packet deframer: input register, parse step, result register.
// Depends on mpd_pkg, mpd_chan_if and mpd_step.
//
// Usage
//   in_if  : one received byte per item (rx_byte), valid/ready.
//   out_if : one result item per input byte: the byte, the current packet's type
//            and flags, the byte's role, its payload offset, the packet end mark,
//            the link state after the byte and the fault code found on it.
//   cfg_if : write of type_limit; always ready. Write only while the block is idle.
//   Path: a byte accepted on in_if is held in the input register, then in the
//   result register, from which it is shown on out_if (two register stages).
//   Throughput: one item per cycle while out_if is not stalled; the whole per-byte
//   parse is one short step between the two registers, so a new byte is taken every cycle.
//   Stall: while out_if is stalled the result register holds its item and the
//   input register still takes one more byte; only then does in_if.ready drop.
//   Reset (rst_n low, synchronous): parser awaits a first byte, link awaits
//   connect, type_limit returns to 15, both stages empty.
//   Once a violation is seen the link stays failed until reset; every later
//   byte passes through marked as ignored.
module mqtt_packet_deframer (
  input  logic        clk,
  input  logic        rst_n,
  mpd_chan_if.sink    in_if,
  mpd_chan_if.source  out_if,
  mpd_chan_if.sink    cfg_if
);
  import mpd_pkg::*;

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       out_valid_r;
  mpd_out_t   out_data_r;
  mpd_state_t state_r;
  mpd_state_t state_nxt;
  mpd_out_t   step_res;
  logic [4:0] type_limit_r;
  logic       advance;
  logic       in_accept;

  // result register can take a new item when empty or being drained
  assign advance   = !out_valid_r || out_if.ready;
  assign in_if.ready = !in_valid_r || advance;
  assign in_accept = in_if.valid && in_if.ready;

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;
  assign cfg_if.ready = 1'b1;

  mpd_step u_step (
    .st         (state_r),
    .rx_byte    (in_byte_r),
    .type_limit (type_limit_r),
    .st_nxt     (state_nxt),
    .res        (step_res)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_limit_r <= TYPE_LIMIT_RST;
    end else if (cfg_if.valid && cfg_if.ready) begin
      type_limit_r <= cfg_if.data.type_limit;
    end
  end

  // input register: load on accept, empty when its item moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_byte_r <= in_if.data.rx_byte;
    end
  end

  // parser state advances exactly once per byte, as it enters the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RST;
    end else if (in_valid_r && advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r && advance) begin
      out_data_r <= step_res;
    end
  end

  // a failed link never recovers short of reset
  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.conn_phase == LK_FAIL |=> state_r.conn_phase == LK_FAIL)
    else $error("link left the failed state without reset");

  // a fault reported on a byte must leave the link failed
  a_fault_fails: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.fault != FLT_NONE |-> out_data_r.link_state == LK_FAIL)
    else $error("fault reported without failing the link");

  // the length field never runs past four bytes while parsing continues
  a_len_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.conn_phase != LK_FAIL |-> state_r.length_byte_count <= LEN_MAX_BYTES)
    else $error("length byte count overran");

  // ignored bytes only come from a failed link
  a_ignored_role: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.byte_role == ROLE_IGNORED |-> out_data_r.link_state == LK_FAIL)
    else $error("ignored byte on a live link");

endmodule
